[design/srtf_pkg.sv]
package srtf_pkg;

  localparam int MaxProcsDef = 16;
  localparam int IdW         = 8;
  localparam int TimeW       = 16;
  localparam int ResW        = 20;
  localparam int SimW        = 21;
  localparam logic [ResW-1:0] ResMax = {ResW{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_RUN,
    ST_EMIT
  } srtf_state_t;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             run;
    logic             shift;
    logic [SimW-1:0]  now;
    logic [TimeW-1:0] amount;
  } srtf_ctl_t;

endpackage

[design/srtf_cell.sv]
module srtf_cell
  import srtf_pkg::*;
(
  input  logic             clk,
  input  srtf_ctl_t        ctl,
  input  logic             sel,
  input  logic             load_here,
  input  logic [IdW-1:0]   in_id,
  input  logic [TimeW-1:0] in_arr,
  input  logic [TimeW-1:0] in_bur,
  input  logic [IdW-1:0]   nb_id,
  input  logic [TimeW-1:0] nb_bur,
  input  logic [ResW-1:0]  nb_wait,
  output logic [IdW-1:0]   id_o,
  output logic [TimeW-1:0] arr_o,
  output logic [TimeW-1:0] bur_o,
  output logic [TimeW-1:0] rem_o,
  output logic [ResW-1:0]  wait_o
);

  logic [IdW-1:0]   id_r;
  logic [TimeW-1:0] arr_r, bur_r, rem_r;
  logic [ResW-1:0]  wait_r;
  logic [SimW:0]    used;
  logic [SimW:0]    w;

  always_comb begin
    used = (SimW+1)'(bur_r) + (SimW+1)'(arr_r);
    w    = (SimW+1)'(ctl.now) + (SimW+1)'(ctl.amount);
    w    = (w > used) ? w - used : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load && load_here) begin
      id_r  <= in_id;
      arr_r <= in_arr;
      bur_r <= in_bur;
    end else if (ctl.start) begin
      rem_r  <= bur_r;
      wait_r <= '0;
    end else if (ctl.run && sel) begin
      rem_r <= rem_r - ctl.amount;
      if (rem_r == ctl.amount)
        wait_r <= (w > (SimW+1)'(ResMax)) ? ResMax : w[ResW-1:0];
    end else if (ctl.shift) begin
      id_r   <= nb_id;
      bur_r  <= nb_bur;
      wait_r <= nb_wait;
    end
  end

  assign id_o   = id_r;
  assign arr_o  = arr_r;
  assign bur_o  = bur_r;
  assign rem_o  = rem_r;
  assign wait_o = wait_r;

endmodule

[design/srtf_wait_time_scheduler.sv]
// Preemptive shortest-remaining-time-first scheduler. Processes load one per
// cycle into a row of MAX_PROCS cells; items beyond MAX_PROCS are dropped. The
// transfer with in_tlast starts scheduling: a start pulse sets up the set,
// then each event takes a scan (the running process stays unless another
// ready one has strictly less remaining time; on a fresh pick the lowest
// index wins) and a run that advances time to completion or to the next
// arrival. A stretch with nothing ready is skipped by a scan that moves time
// to the next arrival, and a last scan finds the set done. Results then
// shift out of the cell row, one per cycle while out_tready is high, in load
// order. Input is held off from the last load until the final result is taken.
module srtf_wait_time_scheduler
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = MaxProcsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // proc_id, arrival_time, burst_time
  input  logic        in_tlast,  // last_proc
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // out_proc_id, waiting_time, turnaround_time
  output logic        out_tlast  // last_result
);

  localparam int IdxW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CntW   = $clog2(MAX_PROCS + 1);
  localparam int Leaves = 1 << IdxW;

  srtf_state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt, emit_r, emit_nxt;
  logic [SimW-1:0] now_r, now_nxt;
  logic            found_r, found_nxt;
  logic [IdxW-1:0] best_r, best_nxt;
  logic [TimeW-1:0] amt_r, amt_nxt;
  srtf_ctl_t ctl, ctl_q;

  logic [IdW-1:0]   id_c   [MAX_PROCS];
  logic [TimeW-1:0] arr_c  [MAX_PROCS];
  logic [TimeW-1:0] bur_c  [MAX_PROCS];
  logic [TimeW-1:0] rem_c  [MAX_PROCS];
  logic [ResW-1:0]  wait_c [MAX_PROCS];

  genvar g;
  generate
    for (g = 0; g < MAX_PROCS; g++) begin : g_cell
      logic [IdW-1:0]   nid;
      logic [TimeW-1:0] nbur;
      logic [ResW-1:0]  nwait;
      if (g == MAX_PROCS - 1) begin : g_end
        assign nid = '0; assign nbur = '0; assign nwait = '0;
      end else begin : g_mid
        assign nid = id_c[g+1]; assign nbur = bur_c[g+1]; assign nwait = wait_c[g+1];
      end
      srtf_cell u_cell (
        .clk,
        .ctl       (ctl_q),
        .sel       (best_r == IdxW'(g)),
        .load_here (cnt_r == CntW'(g)),
        .in_id     (in_tdata[7:0]),
        .in_arr    (in_tdata[23:8]),
        .in_bur    (in_tdata[39:24]),
        .nb_id     (nid),
        .nb_bur    (nbur),
        .nb_wait   (nwait),
        .id_o      (id_c[g]),
        .arr_o     (arr_c[g]),
        .bur_o     (bur_c[g]),
        .rem_o     (rem_c[g]),
        .wait_o    (wait_c[g])
      );
    end
  endgenerate

  // reduce over cells as a tree: best ready process, earliest future arrival
  logic             rdy_v   [2*Leaves];
  logic [TimeW-1:0] rdy_rem [2*Leaves];
  logic [IdxW-1:0]  rdy_idx [2*Leaves];
  logic             fut_v   [2*Leaves];
  logic [TimeW-1:0] fut_arr [2*Leaves];
  logic             s_found;
  logic [IdxW-1:0]  s_idx;
  logic             a_any;
  logic [TimeW-1:0] a_when;
  logic             all_done;
  logic [SimW:0]    tat;

  always_comb begin
    for (int n = 0; n < 2*Leaves; n++) begin
      rdy_v[n]   = 1'b0;
      rdy_rem[n] = '0;
      rdy_idx[n] = '0;
      fut_v[n]   = 1'b0;
      fut_arr[n] = '0;
    end
    for (int i = 0; i < MAX_PROCS; i++) begin
      rdy_idx[Leaves+i] = IdxW'(i);
      rdy_rem[Leaves+i] = rem_c[i];
      fut_arr[Leaves+i] = arr_c[i];
      if (CntW'(i) < cnt_r && rem_c[i] != '0) begin
        if (SimW'(arr_c[i]) <= now_r) rdy_v[Leaves+i] = 1'b1;
        else                          fut_v[Leaves+i] = 1'b1;
      end
    end
    for (int n = Leaves - 1; n > 0; n--) begin
      if (rdy_v[2*n] && (!rdy_v[2*n+1] || rdy_rem[2*n] <= rdy_rem[2*n+1])) begin
        rdy_rem[n] = rdy_rem[2*n];
        rdy_idx[n] = rdy_idx[2*n];
      end else begin
        rdy_rem[n] = rdy_rem[2*n+1];
        rdy_idx[n] = rdy_idx[2*n+1];
      end
      rdy_v[n] = rdy_v[2*n] | rdy_v[2*n+1];
      if (fut_v[2*n] && (!fut_v[2*n+1] || fut_arr[2*n] <= fut_arr[2*n+1]))
        fut_arr[n] = fut_arr[2*n];
      else
        fut_arr[n] = fut_arr[2*n+1];
      fut_v[n] = fut_v[2*n] | fut_v[2*n+1];
    end
    a_any    = fut_v[1];
    a_when   = fut_arr[1];
    all_done = !(rdy_v[1] | fut_v[1]);
    s_found  = found_r | rdy_v[1];
    s_idx    = rdy_idx[1];
    // hold the running process unless another has strictly less remaining
    if (found_r && !(rdy_v[1] && rdy_rem[1] < rem_c[best_r]))
      s_idx = best_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    now_nxt   = now_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    amt_nxt   = amt_r;
    ctl       = '0;
    ctl.now    = now_r;
    ctl.amount = amt_r;
    in_tready  = (state_r == ST_LOAD);
    out_tvalid = (state_r == ST_EMIT);
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CntW'(MAX_PROCS)) begin
            ctl.load = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
          if (in_tlast) begin
            state_nxt = ST_SCAN;
            now_nxt   = '0;
            found_nxt = 1'b0;
            best_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        if (all_done) begin
          state_nxt = ST_EMIT;
          emit_nxt  = '0;
        end else if (!s_found) begin
          now_nxt = SimW'(a_when);
        end else begin
          found_nxt = 1'b1;
          best_nxt  = s_idx;
          amt_nxt   = rem_c[s_idx];
          if (a_any && (SimW'(a_when) - now_r) < SimW'(rem_c[s_idx]))
            amt_nxt = TimeW'(SimW'(a_when) - now_r);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.run   = 1'b1;
        now_nxt   = now_r + SimW'(amt_r);
        if (rem_c[best_r] == amt_r) found_nxt = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_EMIT: begin
        if (out_tready) begin
          ctl.shift = 1'b1;
          emit_nxt  = emit_r + 1'b1;
          if (emit_r + 1'b1 == cnt_r) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // start pulse: initialize remaining on the first scan after load
  logic start_r;
  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= 1'b0;
    else        start_r <= (state_r == ST_LOAD) && in_tvalid && in_tlast;
  end

  always_comb begin
    ctl_q = ctl;
    if (start_r) begin
      ctl_q       = '0;
      ctl_q.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      emit_r  <= '0;
      now_r   <= '0;
      found_r <= 1'b0;
      best_r  <= '0;
      amt_r   <= '0;
    end else if (start_r) begin
      state_r <= ST_SCAN;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
      now_r   <= now_nxt;
      found_r <= found_nxt;
      best_r  <= best_nxt;
      amt_r   <= amt_nxt;
    end
  end

  always_comb begin
    tat = (SimW+1)'(bur_c[0]) + (SimW+1)'(wait_c[0]);
    if (tat > (SimW+1)'(ResMax)) tat = (SimW+1)'(ResMax);
  end

  assign out_tdata = {tat[ResW-1:0], wait_c[0], id_c[0]};
  assign out_tlast = (emit_r + 1'b1 == cnt_r);

endmodule

[tb/srtf_wait_time_scheduler_test.sv]
`timescale 1ns / 100ps

module srtf_wait_time_scheduler_test;
  import srtf_pkg::*;

  localparam int Procs = 16;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [ResW-1:0] waiting;
    logic [ResW-1:0] turnaround;
    logic            last;
  } sched_result_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] arrival;
    logic [TimeW-1:0] burst;
    logic             last;
    logic             typed;
    logic [ResW-1:0]  waiting;
    logic [ResW-1:0]  turnaround;
  } proc_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  srtf_wait_time_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  sched_result_t expected_results[$];
  int unsigned   errors = 0;
  int unsigned   results_seen = 0;
  int unsigned   items_sent = 0;
  int unsigned   sets_sent = 0;
  int unsigned   send_idle = 11;
  int unsigned   recv_idle = 80;

  logic [IdW-1:0]   id_row[Procs];
  logic [TimeW-1:0] arrival_row[Procs];
  logic [TimeW-1:0] burst_row[Procs];
  int unsigned      loaded = 0;

  int unsigned remaining[Procs];
  int unsigned waited[Procs];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[srtf_wait_time_scheduler] ERROR");
    $finish;
  end

  function automatic bit earliest_arrival(int unsigned now, output int unsigned when);
    bit any;
    any = 0;
    when = 0;
    for (int j = 0; j < loaded; j++)
      if (remaining[j] > 0 && arrival_row[j] > now && (!any || arrival_row[j] < when)) begin
        when = arrival_row[j];
        any = 1;
      end
    return any;
  endfunction

  // Run the set to completion and queue one result per stored process.
  task automatic schedule_set();
    int unsigned   now, done, best_rem, best, run, when, used, w, tat;
    bit            found;
    sched_result_t r;
    now = 0;
    done = 0;
    found = 0;
    best_rem = 0;
    best = 0;
    for (int i = 0; i < loaded; i++) begin
      remaining[i] = burst_row[i];
      if (burst_row[i] == 0) begin
        waited[i] = 0;
        done++;
      end
    end
    while (done < loaded) begin
      for (int i = 0; i < loaded; i++)
        if (remaining[i] > 0 && arrival_row[i] <= now && (!found || remaining[i] < best_rem)) begin
          best_rem = remaining[i];
          best = i;
          found = 1;
        end
      if (!found) begin
        if (!earliest_arrival(now, when)) break;
        now = when;
        continue;
      end
      run = remaining[best];
      if (earliest_arrival(now, when) && when - now < run) run = when - now;
      remaining[best] -= run;
      now += run;
      best_rem = remaining[best];
      if (remaining[best] == 0) begin
        used = burst_row[best] + arrival_row[best];
        w = (now > used) ? now - used : 0;
        waited[best] = (w > ResMax) ? ResMax : w;
        done++;
        found = 0;
      end
    end
    for (int i = 0; i < loaded; i++) begin
      tat = burst_row[i] + waited[i];
      r.id = id_row[i];
      r.waiting = waited[i];
      r.turnaround = (tat > ResMax) ? ResMax : tat;
      r.last = (i + 1 == loaded);
      expected_results.push_back(r);
    end
    loaded = 0;
  endtask

  // Entered and left at a falling edge.
  task automatic send_proc(proc_row_t p);
    sched_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.burst, p.arrival, p.id};
    in_tlast  <= p.last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (p.typed) begin
      r.id = p.id;
      r.waiting = p.waiting;
      r.turnaround = p.turnaround;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      if (loaded < Procs) begin
        id_row[loaded] = p.id;
        arrival_row[loaded] = p.arrival;
        burst_row[loaded] = p.burst;
        loaded++;
      end
      if (p.last) schedule_set();
    end
    if (p.last) sets_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    sched_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[27:8], out_tdata[47:28], out_tlast};
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result id=%0d wait=%0d tat=%0d last=%0b",
                 $time, got.id, got.waiting, got.turnaround, got.last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.id != want.id) begin
          $display("%0t: id expected %0d got %0d", $time, want.id, got.id);
          errors++;
        end
        if (got.waiting != want.waiting) begin
          $display("%0t: waiting expected %0d got %0d", $time, want.waiting, got.waiting);
          errors++;
        end
        if (got.turnaround != want.turnaround) begin
          $display("%0t: turnaround expected %0d got %0d", $time, want.turnaround,
                   got.turnaround);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  proc_row_t directed[] = '{
    '{8'h00, 16'h0000, 16'h0001, 1'b1, 1'b1, 20'd0, 20'd1},
    '{8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 20'd0, 20'hFFFF},
    '{8'hAA, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 20'd0, 20'hAAAA},
    '{8'h55, 16'hAAAA, 16'h5555, 1'b1, 1'b1, 20'd0, 20'h5555},
    '{8'd1, 16'd0, 16'd8, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd2, 16'd1, 16'd4, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd3, 16'd2, 16'd9, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd4, 16'd3, 16'd5, 1'b1, 1'b0, 20'd0, 20'd0},
    '{8'd5, 16'd0, 16'd5, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd6, 16'd0, 16'd5, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd7, 16'd2, 16'd3, 1'b1, 1'b0, 20'd0, 20'd0},
    '{8'd8, 16'd10, 16'd3, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd9, 16'd100, 16'd2, 1'b1, 1'b0, 20'd0, 20'd0},
    '{8'd10, 16'd0, 16'hFFFF, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd11, 16'd0, 16'hFFFF, 1'b0, 1'b0, 20'd0, 20'd0},
    '{8'd12, 16'd0, 16'hFFFF, 1'b1, 1'b0, 20'd0, 20'd0}
  };

  initial begin
    proc_row_t   p;
    int unsigned n, span, guard;
    bit          big;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) send_proc(directed[k]);

    while (items_sent < 400) begin
      if (items_sent > 180 && send_idle == 11) begin
        send_idle = 80;
        recv_idle = 11;
      end else if (items_sent > 320 && send_idle == 80) begin
        send_idle = 0;
        recv_idle = 0;
      end
      // Mostly short sets on small times; a few overflow the store or use wide times.
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
      big = ($urandom_range(5) == 0);
      span = big ? 65535 : 24;
      for (int i = 0; i < n; i++) begin
        p = '0;
        p.id = $urandom_range(255);
        p.arrival = $urandom_range(span);
        p.burst = $urandom_range(span, 1);
        p.last = (i == n - 1);
        send_proc(p);
      end
      if (sets_sent % 10 == 0) begin
        in_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
      end
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);

    $display("Sent %0d processes in %0d sets, checked %0d results", items_sent, sets_sent,
             results_seen);
    $display("Covered overflow sets, idle gaps, ties, wide times and both stall patterns");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[srtf_wait_time_scheduler] OK");
    end else begin
      $display("[srtf_wait_time_scheduler] ERROR");
    end
    $finish;
  end

endmodule

[srtf_wait_time_scheduler.f]
design/srtf_pkg.sv
design/srtf_cell.sv
design/srtf_wait_time_scheduler.sv
tb/srtf_wait_time_scheduler_test.sv
